### sv/lslc_pkg.sv
`default_nettype none

package lslc_pkg;

    // sizes
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int DUTY_W          = 10;
    localparam int TICK_W          = 16;
    localparam int BAR_W           = 6;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int BAR_CMP_W       = 16;

    // register reset values
    localparam int SETPOINT_RST        = 1350;
    localparam int SOUND_THRESHOLD_RST = 2500;
    localparam int TIMEOUT_TICKS_RST   = 1600;
    localparam int TRIGGER_DUTY_RST    = 250;
    localparam int PWM_PERIOD_RST      = 500;

    // light bar thresholds
    localparam logic [BAR_CMP_W-1:0] BAR_LVL0 = 16'd300;
    localparam logic [BAR_CMP_W-1:0] BAR_LVL1 = 16'd600;
    localparam logic [BAR_CMP_W-1:0] BAR_LVL2 = 16'd900;
    localparam logic [BAR_CMP_W-1:0] BAR_LVL3 = 16'd1200;
    localparam logic [BAR_CMP_W-1:0] BAR_LVL4 = 16'd1500;
    localparam logic [BAR_CMP_W-1:0] BAR_LVL5 = 16'd1800;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETPOINT        = 3'd0,
        CFG_SOUND_THRESHOLD = 3'd1,
        CFG_TIMEOUT_TICKS   = 3'd2,
        CFG_TRIGGER_DUTY    = 3'd3,
        CFG_PWM_PERIOD      = 3'd4
    } cfg_index_t;

    // item kinds
    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TICK   = 1'b1
    } op_t;

    // control handed from the product stage to the update stage
    typedef struct packed {
        op_t              op;
        logic             raise;
        logic             trig;
        logic [BAR_W-1:0] bar;
    } step_ctl_t;

    // six-segment bar; the top segment needs strictly more than its level
    function automatic logic [BAR_W-1:0] make_bar(input logic [BAR_CMP_W-1:0] light);
        logic [BAR_W-1:0] b;
        b[0] = (light >= BAR_LVL0);
        b[1] = (light >= BAR_LVL1);
        b[2] = (light >= BAR_LVL2);
        b[3] = (light >= BAR_LVL3);
        b[4] = (light >= BAR_LVL4);
        b[5] = (light >  BAR_LVL5);
        return b;
    endfunction

endpackage

`default_nettype wire

### sv/lslc_step.sv
`default_nettype none

module lslc_step #(
    parameter int SAMPLE_BITS = lslc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire lslc_pkg::op_t                          op,
    input  wire logic [SAMPLE_BITS-1:0]                 light,
    input  wire logic [SAMPLE_BITS-1:0]                 sound,
    input  wire logic [SAMPLE_BITS-1:0]                 setpoint,
    input  wire logic [SAMPLE_BITS-1:0]                 sound_threshold,
    input  wire logic [lslc_pkg::DUTY_W-1:0]            pwm_period,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output lslc_pkg::step_ctl_t                         ctl,
    output logic [SAMPLE_BITS+lslc_pkg::DUTY_W-1:0]     prod
);

    localparam int PW = SAMPLE_BITS + lslc_pkg::DUTY_W;

    logic                    valid_reg;
    lslc_pkg::step_ctl_t     ctl_reg;
    lslc_pkg::step_ctl_t     ctl_next;
    logic [PW-1:0]           prod_reg;
    logic [PW-1:0]           prod_next;
    logic [SAMPLE_BITS-1:0]  diff;

    // light error magnitude, direction, trigger compare, light bar and product
    always_comb
    begin
        ctl_next.op    = op;
        ctl_next.raise = (light >= setpoint);
        ctl_next.trig  = (sound >= sound_threshold);
        ctl_next.bar   = lslc_pkg::make_bar(lslc_pkg::BAR_CMP_W'(light));
        diff           = ctl_next.raise ? (light - setpoint) : (setpoint - light);
        prod_next      = PW'(diff) * PW'(pwm_period);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // product register
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ctl_reg  <= ctl_next;
            prod_reg <= prod_next;
        end
    end

    assign out_valid = valid_reg;
    assign ctl       = ctl_reg;
    assign prod      = prod_reg;

endmodule

`default_nettype wire

### sv/lslc_update.sv
`default_nettype none

module lslc_update #(
    parameter int SAMPLE_BITS = lslc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire lslc_pkg::step_ctl_t                    ctl,
    input  wire logic [SAMPLE_BITS+lslc_pkg::DUTY_W-1:0] prod,
    input  wire logic [lslc_pkg::DUTY_W-1:0]            pwm_period,
    input  wire logic [lslc_pkg::DUTY_W-1:0]            trigger_duty,
    input  wire logic [lslc_pkg::TICK_W-1:0]            timeout_ticks,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic [lslc_pkg::DUTY_W-1:0]                 duty,
    output logic [lslc_pkg::BAR_W-1:0]                  level_bar
);

    localparam int PW = SAMPLE_BITS + lslc_pkg::DUTY_W;
    localparam int XW = PW + 1;
    localparam int QW = XW - SAMPLE_BITS;
    localparam int DW = lslc_pkg::DUTY_W;
    localparam logic [XW-1:0] FULL = XW'((64'd1 << SAMPLE_BITS) - 64'd1);

    logic                          valid_reg;
    logic [DW-1:0]                 duty_reg;
    logic [DW-1:0]                 duty_next;
    logic [lslc_pkg::TICK_W-1:0]   tick_reg;
    logic [lslc_pkg::TICK_W-1:0]   tick_next;
    logic [lslc_pkg::BAR_W-1:0]    bar_reg;
    logic [lslc_pkg::BAR_W-1:0]    bar_next;

    logic [XW-1:0]                 x_ext;
    logic [XW-1:0]                 x_sum;
    logic [QW-1:0]                 q_est;
    logic [XW-1:0]                 q_ext;
    logic [XW-1:0]                 rem;
    logic [QW-1:0]                 step;
    logic [DW:0]                   up_sum;
    logic [DW-1:0]                 up_val;
    logic [DW-1:0]                 down_val;
    logic [DW-1:0]                 reg_val;
    logic                          reg_en;
    logic [lslc_pkg::TICK_W-1:0]   tick_inc;

    // divide by full scale: estimate from x * (1 + 2^-n) / 2^n, one correction
    always_comb
    begin
        x_ext = XW'(prod);
        x_sum = x_ext + (x_ext >> SAMPLE_BITS);
        q_est = QW'(x_sum >> SAMPLE_BITS);
        q_ext = XW'(q_est);
        rem   = x_ext + q_ext - (q_ext << SAMPLE_BITS);
        step  = (rem >= FULL) ? (q_est + QW'(1)) : q_est;
    end

    // regulation toward the light error, saturated to 0..period, only while the duty lies strictly between 0 and period
    always_comb
    begin
        reg_en   = (duty_reg != '0) && (duty_reg < pwm_period);
        up_sum   = (DW+1)'(duty_reg) + (DW+1)'(step);
        up_val   = (up_sum > (DW+1)'(pwm_period)) ? pwm_period : up_sum[DW-1:0];
        down_val = ((DW+1)'(step) >= (DW+1)'(duty_reg)) ? '0 : (duty_reg - DW'(step));
        if (reg_en)
        begin
            reg_val = ctl.raise ? up_val : down_val;
        end
        else
        begin
            reg_val = duty_reg;
        end
    end

    // next state for sample and tick items
    always_comb
    begin
        duty_next = duty_reg;
        tick_next = tick_reg;
        bar_next  = bar_reg;
        tick_inc  = tick_reg + lslc_pkg::TICK_W'(1);
        if (in_valid && in_ready)
        begin
            case (ctl.op)
                lslc_pkg::OP_SAMPLE:
                begin
                    bar_next = ctl.bar;
                    if (ctl.trig)
                    begin
                        duty_next = trigger_duty;
                        tick_next = '0;
                    end
                    else
                    begin
                        duty_next = reg_val;
                    end
                end
                lslc_pkg::OP_TICK:
                begin
                    if (tick_inc == timeout_ticks)
                    begin
                        duty_next = '0;
                        tick_next = '0;
                    end
                    else
                    begin
                        tick_next = tick_inc;
                    end
                end
                default:
                begin
                    tick_next = tick_reg;
                end
            endcase
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // state doubles as the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            duty_reg  <= '0;
            tick_reg  <= '0;
            bar_reg   <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            duty_reg <= duty_next;
            tick_reg <= tick_next;
            bar_reg  <= bar_next;
        end
    end

    assign out_valid = valid_reg;
    assign duty      = duty_reg;
    assign level_bar = bar_reg;

endmodule

`default_nettype wire

### sv/light_sound_lamp_controller_unit.sv
// Lamp duty controller. Sensor samples (tuser 0) steer the PWM duty toward the
// light setpoint by floor(|light - setpoint| * period / full scale), clamped to
// 0..period, and a sound level at or above the threshold loads the trigger duty
// and restarts the off timer; timer ticks (tuser 1) count toward the timeout,
// at which the duty drops to 0. Every item gives exactly one result: the duty
// and the six-segment light bar of the last sample. It takes one item per clock
// when the output is not stalled: input register, multiply register, then the
// divide and duty update that writes the result register, where the duty
// feedback closes and sets that rate. Registers must be written by the user
// through the cfg port only while idle; the block itself does not enforce it.
`default_nettype none

module light_sound_lamp_controller_unit #(
    parameter int  SAMPLE_BITS = lslc_pkg::SAMPLE_BITS_DEF,
    localparam int S_DATA_W    = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // sample / tick input
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [S_DATA_W-1:0]                 s_tdata,   // light_level, sound_level, zero pad
    input  wire logic                                s_tuser,   // operation
    // result output
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [15:0]                              m_tdata,   // duty, level_bar
    // register writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [lslc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [lslc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int PW = SAMPLE_BITS + lslc_pkg::DUTY_W;

    logic [SAMPLE_BITS-1:0]             setpoint_reg;
    logic [SAMPLE_BITS-1:0]             sound_threshold_reg;
    logic [lslc_pkg::TICK_W-1:0]        timeout_ticks_reg;
    logic [lslc_pkg::DUTY_W-1:0]        trigger_duty_reg;
    logic [lslc_pkg::DUTY_W-1:0]        pwm_period_reg;

    logic                               s1_valid_reg;
    lslc_pkg::op_t                      s1_op_reg;
    logic [SAMPLE_BITS-1:0]             s1_light_reg;
    logic [SAMPLE_BITS-1:0]             s1_sound_reg;

    logic                               s2_ready;
    logic                               s2_valid;
    lslc_pkg::step_ctl_t                s2_ctl;
    logic [PW-1:0]                      s2_prod;
    logic                               out_ready;
    logic [lslc_pkg::DUTY_W-1:0]        duty;
    logic [lslc_pkg::BAR_W-1:0]         level_bar;

    // register file, always ready for a transfer
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg        <= SAMPLE_BITS'(lslc_pkg::SETPOINT_RST);
            sound_threshold_reg <= SAMPLE_BITS'(lslc_pkg::SOUND_THRESHOLD_RST);
            timeout_ticks_reg   <= lslc_pkg::TICK_W'(lslc_pkg::TIMEOUT_TICKS_RST);
            trigger_duty_reg    <= lslc_pkg::DUTY_W'(lslc_pkg::TRIGGER_DUTY_RST);
            pwm_period_reg      <= lslc_pkg::DUTY_W'(lslc_pkg::PWM_PERIOD_RST);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lslc_pkg::CFG_SETPOINT:
                    setpoint_reg <= cfg_data[SAMPLE_BITS-1:0];
                lslc_pkg::CFG_SOUND_THRESHOLD:
                    sound_threshold_reg <= cfg_data[SAMPLE_BITS-1:0];
                lslc_pkg::CFG_TIMEOUT_TICKS:
                    timeout_ticks_reg <= cfg_data[lslc_pkg::TICK_W-1:0];
                lslc_pkg::CFG_TRIGGER_DUTY:
                    trigger_duty_reg <= cfg_data[lslc_pkg::DUTY_W-1:0];
                lslc_pkg::CFG_PWM_PERIOD:
                    pwm_period_reg <= cfg_data[lslc_pkg::DUTY_W-1:0];
                default:
                    pwm_period_reg <= pwm_period_reg;
            endcase
        end
    end

    // input register
    assign s_tready = !s1_valid_reg || s2_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_op_reg    <= lslc_pkg::op_t'(s_tuser);
            s1_light_reg <= s_tdata[SAMPLE_BITS-1:0];
            s1_sound_reg <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        end
    end

    // error and multiply stage
    lslc_step #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_step (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s1_valid_reg),
        .in_ready        (s2_ready),
        .op              (s1_op_reg),
        .light           (s1_light_reg),
        .sound           (s1_sound_reg),
        .setpoint        (setpoint_reg),
        .sound_threshold (sound_threshold_reg),
        .pwm_period      (pwm_period_reg),
        .out_valid       (s2_valid),
        .out_ready       (out_ready),
        .ctl             (s2_ctl),
        .prod            (s2_prod)
    );

    // divide, duty update and result register
    lslc_update #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_update (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s2_valid),
        .in_ready      (out_ready),
        .ctl           (s2_ctl),
        .prod          (s2_prod),
        .pwm_period    (pwm_period_reg),
        .trigger_duty  (trigger_duty_reg),
        .timeout_ticks (timeout_ticks_reg),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .duty          (duty),
        .level_bar     (level_bar)
    );

    assign m_tdata = {level_bar, duty};

endmodule

`default_nettype wire

### sv/lslc_checker.sv
`default_nettype none

module lslc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    logic [6:0] bar_ext;

    assign bar_ext = {1'b0, m_tdata[15:10]};

    // a stalled result holds still
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

    // a free-running output side never back-pressures the input
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
    else $error("input stalled while output is ready");

    // an accepted item reaches the output through the input, multiply and result registers when nothing stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(s_tvalid && s_tready, 3) && $past(m_tready, 2) && $past(m_tready, 1)
        |-> m_tvalid)
    else $error("result missing after pipeline latency");

    // the light bar fills from the bottom up
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((bar_ext & (bar_ext + 7'd1)) == 7'd0))
    else $error("light bar not a thermometer code");

endmodule

bind light_sound_lamp_controller_unit lslc_checker u_lslc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
